// ===== rtl/core/utf8_surrogate_escape_decoder_top_assert.svh =====
// Assertion macros used by the UTF-8 surrogate-escape decoder top level.
`ifndef UTF8_SURROGATE_ESCAPE_DECODER_TOP_ASSERT_SVH
`define UTF8_SURROGATE_ESCAPE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTF8SE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8SE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/utf8se_pkg.sv =====
// Types and constants for the UTF-8 surrogate-escape decoder.
package utf8se_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] ESCAPE_BASE    = 16'hDC00;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } utf8se_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        was_escaped;
    logic        run_last;
  } utf8se_out_t;

  // Bytes of an open sequence; entry 0 is its lead byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic [2:0]      exp_len;
  } utf8se_pend_t;

endpackage

// ===== rtl/core/utf8se_decode.sv =====
// Combinational decode of pending bytes plus one new byte into up to four code units.
module utf8se_decode (
  input  utf8se_pkg::utf8se_pend_t                                 pend,
  input  utf8se_pkg::utf8se_in_t                                   in_word,
  output utf8se_pkg::utf8se_pend_t                                 pend_next,
  output utf8se_pkg::utf8se_out_t [utf8se_pkg::MAX_RESULTS-1:0]    units,
  output logic [utf8se_pkg::NUM_W-1:0]                             num
);

  typedef struct packed {
    logic        ok;
    logic [20:0] cp;
  } check_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] r;
    if ((lead & 8'hF8) == 8'hF0)      r = 3'd4;
    else if ((lead & 8'hF0) == 8'hE0) r = 3'd3;
    else if ((lead & 8'hE0) == 8'hC0) r = 3'd2;
    else                              r = 3'd1;
    return r;
  endfunction

  // Drop the first p bytes of the window; empty slots read as zero.
  function automatic logic [3:0][7:0] shift_win(input logic [3:0][7:0] bv, input logic [2:0] p);
    logic [31:0] raw;
    raw = 32'(bv) >> {p, 3'b000};
    return raw;
  endfunction

  function automatic check_t check_window(input logic [3:0][7:0] w, input logic [2:0] len);
    check_t r;
    logic   c1, c2, c3;
    c1 = (w[1][7:6] == 2'b10);
    c2 = (w[2][7:6] == 2'b10);
    c3 = (w[3][7:6] == 2'b10);
    r  = '0;
    case (len)
      3'd1: begin
        r.cp = {13'd0, w[0]};
        r.ok = !w[0][7];
      end
      3'd2: begin
        r.cp = {10'd0, w[0][4:0], w[1][5:0]};
        r.ok = c1 && (r.cp >= 21'h80);
      end
      3'd3: begin
        r.cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
        r.ok = c1 && c2 && (r.cp >= 21'h800) && !((r.cp >= 21'hD800) && (r.cp <= 21'hDFFF));
      end
      3'd4: begin
        r.cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        r.ok = c1 && c2 && c3 && (r.cp >= 21'h10000) && (r.cp <= 21'h10FFFF);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic utf8se_pkg::utf8se_out_t esc_unit(input logic [7:0] b);
    utf8se_pkg::utf8se_out_t u;
    u.code_unit   = utf8se_pkg::ESCAPE_BASE + {8'd0, b};
    u.was_escaped = 1'b1;
    u.run_last    = 1'b0;
    return u;
  endfunction

  always_comb begin
    logic [3:0][7:0] bv;
    logic [3:0][7:0] w;
    logic [3:0][7:0] nw;
    logic [2:0]      n;
    logic [2:0]      pos;
    logic [2:0]      len;
    logic [2:0]      avail;
    logic [2:0]      rem;
    logic            done;
    check_t          chk;
    logic [19:0]     sub;

    bv = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pend.count) bv[k] = pend.bytes[k];
    end
    bv[pend.count] = in_word.in_byte;
    n     = {1'b0, pend.count} + 3'd1;
    pos   = '0;
    num   = '0;
    done  = 1'b0;
    units = '0;
    w     = '0;
    len   = '0;
    avail = '0;
    chk   = '0;
    sub   = '0;

    // Each step resolves one window: wait, escape the lead, or emit a character.
    for (int s = 0; s < utf8se_pkg::MAX_RESULTS; s++) begin
      if (!done && (pos < n)) begin
        w     = shift_win(bv, pos);
        len   = (s == 0 && pend.count != 2'd0) ? pend.exp_len : seq_len(w[0]);
        avail = n - pos;
        chk   = check_window(w, len);
        if (avail < len) begin
          if (!in_word.end_of_stream) begin
            done = 1'b1;
          end else begin
            units[num[1:0]] = esc_unit(w[0]);
            num = num + 3'd1;
            pos = pos + 3'd1;
          end
        end else if (chk.ok) begin
          if (len == 3'd4) begin
            sub = 20'(chk.cp - 21'h10000);
            units[num[1:0]].code_unit         = utf8se_pkg::HIGH_SURR_BASE + {6'd0, sub[19:10]};
            units[num[1:0]].was_escaped       = 1'b0;
            units[num[1:0]+2'd1].code_unit    = utf8se_pkg::LOW_SURR_BASE + {6'd0, sub[9:0]};
            units[num[1:0]+2'd1].was_escaped  = 1'b0;
            num = num + 3'd2;
          end else begin
            units[num[1:0]].code_unit   = chk.cp[15:0];
            units[num[1:0]].was_escaped = 1'b0;
            num = num + 3'd1;
          end
          pos = pos + len;
        end else begin
          units[num[1:0]] = esc_unit(w[0]);
          num = num + 3'd1;
          pos = pos + 3'd1;
        end
      end
    end

    if (num != '0) units[2'(num - 3'd1)].run_last = 1'b1;

    // Hold the unresolved tail for the next word.
    rem                = n - pos;
    nw                 = shift_win(bv, pos);
    pend_next.bytes    = nw[2:0];
    pend_next.count    = rem[1:0];
    pend_next.exp_len  = (rem != 3'd0) ? seq_len(nw[0]) : 3'd0;
  end

endmodule

// ===== rtl/core/utf8se_fifo.sv =====
// Result queue: takes up to four code units per cycle on wr_en, hands out one per cycle on rd_en.
module utf8se_fifo (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  wr_en,
  input  logic [utf8se_pkg::NUM_W-1:0]                          wr_num,
  input  utf8se_pkg::utf8se_out_t [utf8se_pkg::MAX_RESULTS-1:0] wr_units,
  input  logic                                                  rd_en,
  output utf8se_pkg::utf8se_out_t                               rd_data,
  output logic [utf8se_pkg::FIFO_CNT_W-1:0]                     count
);

  utf8se_pkg::utf8se_out_t                mem [utf8se_pkg::FIFO_DEPTH];
  logic [utf8se_pkg::FIFO_PTR_W-1:0]      wptr;
  logic [utf8se_pkg::FIFO_PTR_W-1:0]      rptr;
  logic [utf8se_pkg::FIFO_CNT_W-1:0]      wr_add;

  assign wr_add  = wr_en ? utf8se_pkg::FIFO_CNT_W'(wr_num) : '0;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < utf8se_pkg::MAX_RESULTS; k++) begin
        if (utf8se_pkg::NUM_W'(k) < wr_num) begin
          mem[wptr + utf8se_pkg::FIFO_PTR_W'(k)] <= wr_units[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + utf8se_pkg::FIFO_PTR_W'(wr_add);
      rptr  <= rptr + utf8se_pkg::FIFO_PTR_W'(rd_en);
      count <= count + wr_add - utf8se_pkg::FIFO_CNT_W'(rd_en);
    end
  end

endmodule

// ===== rtl/core/utf8_surrogate_escape_decoder_top.sv =====
// Top level of the UTF-8 to UTF-16 decoder with surrogate escaping of bad bytes.
//
// Input channel (in_valid/in_stall/in_data): one UTF-8 byte per word, with
// end_of_stream on the final byte of a stream. Output channel
// (out_valid/out_stall/out_data): one UTF-16 code unit per word, with
// was_escaped on units of the form 0xDC00 + byte, and run_last on the last
// unit caused by a given input byte. A byte that only extends an open
// sequence causes no output word.
// Throughput: one input byte per cycle while in_stall is low. Each byte is decoded in
// the cycle it is accepted, against up to three held bytes, and its units
// (up to four) go into an eight-entry result queue that drains one per cycle
// while out_stall is low. With an empty queue, the first unit of a byte is
// valid in the cycle after acceptance; later units wait behind those queued ahead.
// in_stall rises while the queue holds more than four units, so a burst of
// results never overflows it; a stream never yields more units than bytes.
// Reset (synchronous, rst high): empties the queue and drops any open sequence.
// A stalled output word stays on out_data until taken.
module utf8_surrogate_escape_decoder_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  utf8se_pkg::utf8se_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output utf8se_pkg::utf8se_out_t out_data
);

  `include "utf8_surrogate_escape_decoder_top_assert.svh"

  // Open-sequence state: bytes carry no reset, count and length do.
  logic [2:0][7:0] pend_bytes;
  logic [1:0]      pend_count;
  logic [2:0]      exp_len;

  utf8se_pkg::utf8se_pend_t                                 pend;
  utf8se_pkg::utf8se_pend_t                                 pend_next;
  utf8se_pkg::utf8se_out_t [utf8se_pkg::MAX_RESULTS-1:0]    dec_units;
  logic [utf8se_pkg::NUM_W-1:0]                             dec_num;
  logic [utf8se_pkg::FIFO_CNT_W-1:0]                        fifo_count;
  logic                                                     in_accept;
  logic                                                     out_take;

  assign pend.bytes   = pend_bytes;
  assign pend.count   = pend_count;
  assign pend.exp_len = exp_len;

  // Stall while a worst-case burst of units might not fit in the queue.
  assign in_stall  = fifo_count >
                     utf8se_pkg::FIFO_CNT_W'(utf8se_pkg::FIFO_DEPTH - utf8se_pkg::MAX_RESULTS);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = fifo_count != '0;
  assign out_take  = out_valid && !out_stall;

  utf8se_decode u_decode (
    .pend      (pend),
    .in_word   (in_data),
    .pend_next (pend_next),
    .units     (dec_units),
    .num       (dec_num)
  );

  utf8se_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_accept),
    .wr_num   (dec_num),
    .wr_units (dec_units),
    .rd_en    (out_take),
    .rd_data  (out_data),
    .count    (fifo_count)
  );

  // Advance the held bytes on every accepted word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_bytes <= pend_next.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      exp_len    <= '0;
    end else if (in_accept) begin
      pend_count <= pend_next.count;
      exp_len    <= pend_next.exp_len;
    end
  end

  // Held count and held sequence length are empty together.
  `UTF8SE_ASSERT_NOW(a_pend_len_match, clk, rst, 1'b1,
    (pend_count == 2'd0) == (exp_len == 3'd0), "pending count and length disagree")

  // End of stream resolves every held byte.
  `UTF8SE_ASSERT_NEXT(a_eos_flush, clk, rst, in_accept && in_data.end_of_stream,
    pend_count == 2'd0, "bytes left pending after end of stream")

  // A final byte always yields at least one unit.
  `UTF8SE_ASSERT_NOW(a_eos_output, clk, rst, in_accept && in_data.end_of_stream,
    dec_num != '0, "end of stream produced no code unit")

endmodule

// ===== test/utf8se_decode_checker.sv =====
// Checker for the UTF-8 surrogate-escape decoder: predicts code units and compares them.
module utf8se_decode_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  utf8se_pkg::utf8se_in_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  utf8se_pkg::utf8se_out_t out_data,
  output int                      fail_count,
  output int                      units_waiting
);

  logic [7:0]              held_bytes [0:2];
  int                      held_count;
  utf8se_pkg::utf8se_out_t unit_q [$];

  function automatic int lead_length(input logic [7:0] lead);
    if ((lead & 8'hF8) == 8'hF0) return 4;
    if ((lead & 8'hF0) == 8'hE0) return 3;
    if ((lead & 8'hE0) == 8'hC0) return 2;
    return 1;
  endfunction

  // Return 1 and the code point when the window is a well-formed sequence.
  function automatic bit window_ok(input logic [7:0] b0, b1, b2, b3, input int len,
                                   output logic [20:0] cp);
    cp = '0;
    case (len)
      1: begin
        cp = {13'd0, b0};
        return b0 < 8'h80;
      end
      2: begin
        if (b1[7:6] != 2'b10) return 0;
        cp = {10'd0, b0[4:0], b1[5:0]};
        return cp >= 21'h80;
      end
      3: begin
        if (b1[7:6] != 2'b10 || b2[7:6] != 2'b10) return 0;
        cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        return cp >= 21'h800 && !(cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: begin
        if (b1[7:6] != 2'b10 || b2[7:6] != 2'b10 || b3[7:6] != 2'b10) return 0;
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        return cp >= 21'h10000 && cp <= 21'h10FFFF;
      end
    endcase
  endfunction

  function automatic utf8se_pkg::utf8se_out_t make_unit(input logic [15:0] code,
                                                        input logic esc);
    utf8se_pkg::utf8se_out_t u;
    u.code_unit   = code;
    u.was_escaped = esc;
    u.run_last    = 1'b0;
    return u;
  endfunction

  // Decode one accepted byte against the held bytes and queue its code units.
  task automatic predict_units(input utf8se_pkg::utf8se_in_t w);
    logic [7:0]              window [0:6];
    utf8se_pkg::utf8se_out_t step_units [0:3];
    logic [20:0]             cp;
    logic [19:0]             offset;
    int                      n, pos, len, k, count;
    bit                      waiting;
    for (k = 0; k < 7; k++) window[k] = 8'h00;
    for (k = 0; k < held_count; k++) window[k] = held_bytes[k];
    window[held_count] = w.in_byte;
    n = held_count + 1;
    pos = 0;
    count = 0;
    waiting = 0;
    while (pos < n && !waiting) begin
      len = lead_length(window[pos]);
      if (n - pos < len && !w.end_of_stream) begin
        waiting = 1;
      end else if (n - pos >= len &&
                   window_ok(window[pos], window[pos+1], window[pos+2], window[pos+3],
                             len, cp)) begin
        if (cp >= 21'h10000) begin
          offset = 20'(cp - 21'h10000);
          step_units[count]   = make_unit(utf8se_pkg::HIGH_SURR_BASE + offset[19:10], 1'b0);
          step_units[count+1] = make_unit(utf8se_pkg::LOW_SURR_BASE + offset[9:0], 1'b0);
          count += 2;
        end else begin
          step_units[count] = make_unit(cp[15:0], 1'b0);
          count++;
        end
        pos += len;
      end else begin
        // Escape the lead alone; the bytes after it start over.
        step_units[count] = make_unit(utf8se_pkg::ESCAPE_BASE + window[pos], 1'b1);
        count++;
        pos++;
      end
    end
    held_count = n - pos;
    for (k = 0; k < held_count; k++) held_bytes[k] = window[pos+k];
    if (count > 0) step_units[count-1].run_last = 1'b1;
    for (k = 0; k < count; k++) unit_q.push_back(step_units[k]);
  endtask

  task automatic check_unit(input utf8se_pkg::utf8se_out_t got);
    utf8se_pkg::utf8se_out_t want;
    if (unit_q.size() == 0) begin
      $display("%0t: unexpected unit: expected none, got code_unit %h esc %b last %b",
               $time, got.code_unit, got.was_escaped, got.run_last);
      fail_count++;
    end else begin
      want = unit_q.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $display("%0t: code_unit mismatch: expected %h, got %h",
                 $time, want.code_unit, got.code_unit);
        fail_count++;
      end
      if (got.was_escaped !== want.was_escaped) begin
        $display("%0t: was_escaped mismatch on %h: expected %b, got %b",
                 $time, want.code_unit, want.was_escaped, got.was_escaped);
        fail_count++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last mismatch on %h: expected %b, got %b",
                 $time, want.code_unit, want.run_last, got.run_last);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    held_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      unit_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_units(in_data);
      if (out_valid && !out_stall) check_unit(out_data);
    end
    units_waiting <= unit_q.size();
  end

endmodule

// ===== test/utf8_surrogate_escape_decoder_top_tb.sv =====
// Testbench top for the UTF-8 surrogate-escape decoder: stimulus, idling and verdict.
module utf8_surrogate_escape_decoder_top_tb;

  localparam int RANDOM_WORDS     = 200;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int QUIET_WORDS      = 40;
  localparam int DRAIN_CYCLES     = 16;
  localparam int CYCLE_LIMIT      = 200000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  utf8se_pkg::utf8se_in_t  in_data;
  logic                    out_valid;
  logic                    out_stall;
  utf8se_pkg::utf8se_out_t out_data;

  int fail_count;
  int units_waiting;
  int cycle_count;
  int directed_words;

  // Words to send, built before reset is released.
  utf8se_pkg::utf8se_in_t stim_q [$];

  // Knobs shared by the sender and the receiver.
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit long_hold_req = 1'b0;

  utf8_surrogate_escape_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  utf8se_decode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .units_waiting (units_waiting)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one word to the stimulus.
  task automatic push_word(input logic [7:0] b, input bit eos);
    utf8se_pkg::utf8se_in_t w;
    w.in_byte       = b;
    w.end_of_stream = eos;
    stim_q.push_back(w);
  endtask

  // Append the first len bytes of seq (lead in the top byte); a rare byte closes the stream.
  task automatic push_bytes(input logic [31:0] seq, input int len);
    int k;
    for (k = 0; k < len; k++) push_word(seq[31-8*k -: 8], $urandom_range(0, 24) == 0);
  endtask

  // Encode a valid code point; the lead byte lands in the top byte.
  function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] seq);
    seq = '0;
    if (cp < 21'h80) begin
      seq[31:24] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      seq[31:16] = {3'b110, cp[10:6], 2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      seq[31:8] = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      return 3;
    end
    seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    return 4;
  endfunction

  // Pick a code point whose shortest encoding has len bytes, skipping surrogates.
  function automatic logic [20:0] random_code_point(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'hD800) cp += 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Mostly well-formed characters; the rest are noise and broken sequences.
  task automatic add_random_piece();
    logic [31:0] seq;
    logic [31:0] r;
    int          kind, len, pos;
    kind = $urandom_range(0, 19);
    r = $urandom();
    if (kind == 15 || kind == 16) len = utf8_encode(random_code_point($urandom_range(2, 4)), seq);
    else len = utf8_encode(random_code_point($urandom_range(1, 4)), seq);
    case (kind)
      14: push_word(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
      // Cut a sequence short; the next piece interrupts it.
      15: push_bytes(seq, $urandom_range(1, len - 1));
      // Corrupt one continuation byte.
      16: begin
        pos = $urandom_range(1, len - 1);
        seq[31-8*pos -: 8] = 8'($urandom_range(0, 255));
        push_bytes(seq, len);
      end
      // Overlong forms of every length.
      17: begin
        case (r[31:30])
          2'd0:    push_bytes({7'b1100000, r[0], 2'b10, r[6:1], 16'h0000}, 2);
          2'd1:    push_bytes({8'hE0, 3'b100, r[4:0], 2'b10, r[10:5], 8'h00}, 3);
          default: push_bytes({8'hF0, 4'b1000, r[3:0], 2'b10, r[9:4], 2'b10, r[15:10]}, 4);
        endcase
      end
      // Encoded surrogate code point.
      18: push_bytes({8'hED, 3'b101, r[4:0], 2'b10, r[10:5], 8'h00}, 3);
      // Beyond the last code point.
      19: push_bytes({8'hF4 + r[1:0], 3'b101, r[6:2], 2'b10, r[12:7], 2'b10, r[18:13]}, 4);
      default: push_bytes(seq, len);
    endcase
  endtask

  // Receiver: stall in random bursts, with free-running stretches between them,
  // and one long hold-off that backs the block up into its input.
  initial begin
    bit stall_val;
    int span;
    forever begin
      if (long_hold_req) begin
        stall_val = 1'b1;
        span = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        stall_val = 1'b1;
        span = $urandom_range(1, 14);
      end else begin
        stall_val = 1'b0;
        span = $urandom_range(1, 20);
      end
      @(negedge clk);
      out_stall <= stall_val;
      repeat (span - 1) @(negedge clk);
    end
  end

  // Watchdog: count cycles and give up at a generous limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Sender and verdict.
  initial begin
    int idx, gap, pressure_at, quiet_from;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;

    // Directed words: U+0000, U+007F, U+0080, U+10FFFF, the byte order mark,
    // stray and out-of-range bytes, overlong, surrogate and too-large forms,
    // a lead interrupted by ASCII, and a sequence cut off by end of stream.
    push_word(8'h00, 1'b0);
    push_word(8'h7F, 1'b0);
    push_bytes({8'hC2, 8'h80, 16'h0000}, 2);
    push_word(8'hEF, 1'b0);
    push_word(8'hBB, 1'b0);
    push_word(8'hBF, 1'b0);
    push_bytes({8'hF4, 8'h8F, 8'hBF, 8'hBF}, 4);
    push_word(8'h80, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hC0, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'hED, 1'b0);
    push_word(8'hA0, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'hF4, 1'b0);
    push_word(8'h90, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'hE2, 1'b0);
    push_word(8'h41, 1'b0);
    push_word(8'hE2, 1'b0);
    push_word(8'h82, 1'b1);
    directed_words = stim_q.size();

    while (stim_q.size() < directed_words + RANDOM_WORDS) add_random_piece();
    // Close the stream so nothing stays held at the end.
    push_word(8'h2E, 1'b1);

    pressure_at = directed_words + 40;
    quiet_from  = stim_q.size() - QUIET_WORDS;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < stim_q.size(); idx++) begin
      if (idx == pressure_at) long_hold_req = 1'b1;
      // Run the tail of the stream at full rate on both sides.
      if (idx >= quiet_from) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_data  <= stim_q[idx];
      // Hold the word until it is taken.
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Let the count of waiting units catch up with the last word, then drain.
    @(posedge clk);
    while (units_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
